// ===== src/mlft_pkg.sv =====
// ----------------------------------------------------------------------------
// mlft_pkg
// shared types and codes for the mac learning forwarding table
// ----------------------------------------------------------------------------
package mlft_pkg;

    localparam int MAC_W       = 48;
    localparam int PORT_W      = 16;
    localparam int ETYPE_W     = 16;
    localparam int HASH_W      = 8;
    localparam int HASH_RANGE  = 256;
    localparam int GROUP_BIT   = 40;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [ETYPE_W-1:0] LLDP_TYPE = 16'h88cc;

    // verdict codes
    localparam logic [2:0] V_DROP  = 3'd0;
    localparam logic [2:0] V_FWD   = 3'd1;
    localparam logic [2:0] V_FLOOD = 3'd2;
    localparam logic [2:0] V_MCAST = 3'd3;
    localparam logic [2:0] V_LLDP  = 3'd4;

    // learn event codes
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_NEW   = 2'd1;
    localparam logic [1:0] EV_MOVED = 2'd2;
    localparam logic [1:0] EV_FULL  = 2'd3;

    // frame classes set by the front end
    localparam logic [1:0] CLS_INVALID = 2'd0;
    localparam logic [1:0] CLS_MCAST   = 2'd1;
    localparam logic [1:0] CLS_LLDP    = 2'd2;
    localparam logic [1:0] CLS_NORMAL  = 2'd3;

    typedef struct packed {
        logic [MAC_W-1:0]   src_mac;
        logic [MAC_W-1:0]   dst_mac;
        logic [ETYPE_W-1:0] ether_type;
        logic [PORT_W-1:0]  in_port;
    } t_in;

    typedef struct packed {
        logic [2:0]        verdict;
        logic [PORT_W-1:0] out_port;
        logic [1:0]        learn_event;
        logic [PORT_W-1:0] old_port;
    } t_out;

    typedef struct packed {
        logic [1:0]        cls;
        logic [HASH_W-1:0] src_hash;
        logic [HASH_W-1:0] dst_hash;
        logic [MAC_W-1:0]  src_mac;
        logic [MAC_W-1:0]  dst_mac;
        logic [PORT_W-1:0] in_port;
    } t_item;

    typedef struct packed {
        logic              valid;
        logic [MAC_W-1:0]  mac;
        logic [PORT_W-1:0] port;
    } t_entry;

endpackage

// ===== src/mlft_front.sv =====
// ----------------------------------------------------------------------------
// mlft_front
// classifies an incoming word and folds both macs into octet hashes
// ----------------------------------------------------------------------------
module mlft_front (
    input  mlft_pkg::t_in   i_word,
    output mlft_pkg::t_item o_item
);
    import mlft_pkg::*;

    function automatic logic [HASH_W-1:0] mac_fold(input logic [MAC_W-1:0] mac);
        logic [HASH_W-1:0] x;
        x = '0;
        for (int i = 0; i < MAC_W / HASH_W; i++) begin
            x = x ^ mac[i*HASH_W +: HASH_W];
        end
        return x;
    endfunction

    logic bad_frame;

    assign bad_frame = (i_word.src_mac == '0) || (i_word.dst_mac == '0)
                     || i_word.src_mac[GROUP_BIT];

    always_comb begin
        o_item.src_hash = mac_fold(i_word.src_mac);
        o_item.dst_hash = mac_fold(i_word.dst_mac);
        o_item.src_mac  = i_word.src_mac;
        o_item.dst_mac  = i_word.dst_mac;
        o_item.in_port  = i_word.in_port;
        priority if (bad_frame) begin
            o_item.cls = CLS_INVALID;
        end else if (i_word.dst_mac[GROUP_BIT]) begin
            o_item.cls = (i_word.ether_type == LLDP_TYPE) ? CLS_LLDP : CLS_MCAST;
        end else begin
            o_item.cls = CLS_NORMAL;
        end
    end

endmodule

// ===== src/mlft_queue.sv =====
// ----------------------------------------------------------------------------
// mlft_queue
// two-entry queue between the classifier and the table engine
// ----------------------------------------------------------------------------
module mlft_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mlft_pkg::t_item i_item,
    output logic            o_full,
    output logic            o_valid,
    output mlft_pkg::t_item o_item,
    input  logic            i_pop
);
    import mlft_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item             r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [PTR_W-1:0]  r_rp, n_rp;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_q[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_item;
        end
    end

endmodule

// ===== src/mlft_back.sv =====
// ----------------------------------------------------------------------------
// mlft_back
// table engine: source learn with write-back, then destination lookup
// ----------------------------------------------------------------------------
module mlft_back #(
    parameter int SETS = 256,
    parameter int WAYS = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  mlft_pkg::t_item i_q_item,
    output logic            o_q_pop,
    output logic            o_clearing,
    output logic            o_valid,
    input  logic            i_ready,
    output mlft_pkg::t_out  o_data
);
    import mlft_pkg::*;

    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LRN  = 2'd1;
    localparam logic [1:0] ST_DST  = 2'd2;

    typedef t_entry [WAYS-1:0] t_row;
    typedef logic [SET_W-1:0] t_set_tab [HASH_RANGE];

    function automatic t_set_tab set_tab_f();
        t_set_tab tab;
        for (int i = 0; i < HASH_RANGE; i++) begin
            tab[i] = SET_W'(i % SETS);
        end
        return tab;
    endfunction

    localparam t_set_tab SET_TAB = set_tab_f();

    t_row               r_mem [SETS];
    t_row               r_rdata;
    t_row               r_byp;
    logic               r_same;
    logic [1:0]         r_state, n_state;
    logic               r_clearing;
    logic [SET_W-1:0]   r_clr_cnt;
    logic [MAC_W-1:0]   r_src, r_dst;
    logic [PORT_W-1:0]  r_port;
    logic [SET_W-1:0]   r_src_set, r_dst_set;
    logic [1:0]         r_ev;
    logic [PORT_W-1:0]  r_oldp;
    t_out               r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic               rd_en, wr_en, load_item, out_free, head_normal;
    logic [SET_W-1:0]   rd_addr, wr_addr;
    logic [SET_W-1:0]   head_src_set, head_dst_set;
    t_row               wr_row;

    t_row               lrn_row;
    logic [WAYS-1:0]    src_hit, way_free;
    logic [WAY_W-1:0]   hit_way, free_way;
    logic [1:0]         lrn_ev;
    logic [PORT_W-1:0]  lrn_old;
    logic               lrn_wr;

    t_row               dst_row;
    logic [WAYS-1:0]    dst_hit;
    logic [PORT_W-1:0]  dst_port;
    t_out               dst_out, cls_out;

    assign head_src_set = SET_TAB[i_q_item.src_hash];
    assign head_dst_set = SET_TAB[i_q_item.dst_hash];
    assign head_normal  = (i_q_item.cls == CLS_NORMAL);
    assign out_free     = !r_out_valid || i_ready;

    // learn step on the source row
    always_comb begin
        src_hit  = '0;
        way_free = '0;
        hit_way  = '0;
        free_way = '0;
        lrn_row  = r_rdata;
        lrn_ev   = EV_NONE;
        lrn_old  = '0;
        lrn_wr   = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
            src_hit[w]  = r_rdata[w].valid && (r_rdata[w].mac == r_src);
            way_free[w] = !r_rdata[w].valid;
        end
        // lowest-numbered way wins
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (src_hit[w]) begin
                hit_way = WAY_W'(w);
            end
            if (way_free[w]) begin
                free_way = WAY_W'(w);
            end
        end
        if (|src_hit) begin
            if (r_rdata[hit_way].port != r_port) begin
                lrn_ev                = EV_MOVED;
                lrn_old               = r_rdata[hit_way].port;
                lrn_row[hit_way].port = r_port;
                lrn_wr                = 1'b1;
            end
        end else if (|way_free) begin
            lrn_ev                  = EV_NEW;
            lrn_row[free_way].valid = 1'b1;
            lrn_row[free_way].mac   = r_src;
            lrn_row[free_way].port  = r_port;
            lrn_wr                  = 1'b1;
        end else begin
            lrn_ev = EV_FULL;
        end
    end

    // destination lookup, row just written comes from the bypass
    always_comb begin
        dst_row  = r_same ? r_byp : r_rdata;
        dst_hit  = '0;
        dst_port = '0;
        for (int w = 0; w < WAYS; w++) begin
            dst_hit[w] = dst_row[w].valid && (dst_row[w].mac == r_dst);
            if (dst_hit[w]) begin
                dst_port = dst_port | dst_row[w].port;
            end
        end
        dst_out.verdict     = (|dst_hit) ? V_FWD : V_FLOOD;
        dst_out.out_port    = dst_port;
        dst_out.learn_event = r_ev;
        dst_out.old_port    = r_oldp;
    end

    always_comb begin
        cls_out.out_port    = '0;
        cls_out.learn_event = EV_NONE;
        cls_out.old_port    = '0;
        unique case (i_q_item.cls)
            CLS_MCAST: cls_out.verdict = V_MCAST;
            CLS_LLDP:  cls_out.verdict = V_LLDP;
            default:   cls_out.verdict = V_DROP;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        o_q_pop     = 1'b0;
        load_item   = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = head_src_set;
        wr_en       = 1'b0;
        wr_addr     = r_src_set;
        wr_row      = lrn_row;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        if (r_clearing) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_cnt;
            wr_row  = '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        if (head_normal) begin
                            o_q_pop   = 1'b1;
                            load_item = 1'b1;
                            rd_en     = 1'b1;
                            n_state   = ST_LRN;
                        end else if (out_free) begin
                            o_q_pop     = 1'b1;
                            n_out       = cls_out;
                            n_out_valid = 1'b1;
                        end
                    end
                end
                ST_LRN: begin
                    wr_en   = lrn_wr;
                    rd_en   = 1'b1;
                    rd_addr = r_dst_set;
                    n_state = ST_DST;
                end
                ST_DST: begin
                    if (out_free) begin
                        n_out       = dst_out;
                        n_out_valid = 1'b1;
                        // next learned frame reads while this result is loaded
                        if (i_q_valid && head_normal) begin
                            o_q_pop   = 1'b1;
                            load_item = 1'b1;
                            rd_en     = 1'b1;
                            n_state   = ST_LRN;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_clearing  <= 1'b1;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (r_clearing) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == SET_W'(SETS - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (load_item) begin
            r_src     <= i_q_item.src_mac;
            r_dst     <= i_q_item.dst_mac;
            r_port    <= i_q_item.in_port;
            r_src_set <= head_src_set;
            r_dst_set <= head_dst_set;
        end
        if (r_state == ST_LRN) begin
            r_ev   <= lrn_ev;
            r_oldp <= lrn_old;
            r_byp  <= lrn_row;
            r_same <= (r_src_set == r_dst_set);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_row;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    assign o_clearing = r_clearing;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;

endmodule

// ===== src/mac_learning_forwarding_table.sv =====
// learned frames: queue entry, source row read, learn and write-back, destination row
// read, result register; both row reads share the single table read port; dropped,
// multicast and lldp frames: queue entry, result register, one per cycle while the
// engine is idle and the output is not stalled; reset: synchronous active low, then a
// clearing pass zeroes the table one row a cycle and o_ready stays low until it ends
// ----------------------------------------------------------------------------
// mac_learning_forwarding_table
// ethernet bridge table: classifier, two-entry queue and learn/lookup engine
// ----------------------------------------------------------------------------
module mac_learning_forwarding_table #(
    parameter int SETS = 256,
    parameter int WAYS = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  mlft_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output mlft_pkg::t_out o_data
);
    import mlft_pkg::*;

    t_item front_item, q_item;
    logic  q_full, q_valid, q_pop, clearing, push;

    assign o_ready = !q_full && !clearing;
    assign push    = i_valid && o_ready;

    mlft_front u_front (
        .i_word (i_data),
        .o_item (front_item)
    );

    mlft_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    mlft_back #(
        .SETS (SETS),
        .WAYS (WAYS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_item   (q_item),
        .o_q_pop    (q_pop),
        .o_clearing (clearing),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data)
    );

endmodule

// ===== src/mlft_checker.sv =====
// ----------------------------------------------------------------------------
// mlft_assert
// port-level checks on the result channel of the forwarding table
// ----------------------------------------------------------------------------
module mlft_assert (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_valid,
    input logic           i_ready,
    input mlft_pkg::t_out o_data
);
    import mlft_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result word dropped before accept");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_data))
        else $error("result word changed while stalled");

    a_port_fwd_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.verdict != V_FWD) |-> (o_data.out_port == '0))
        else $error("egress port set on a non-forward verdict");

    a_old_port_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.learn_event != EV_MOVED) |-> (o_data.old_port == '0))
        else $error("old port set without a station move");

    a_no_learn_on_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.verdict == V_DROP || o_data.verdict == V_MCAST
                    || o_data.verdict == V_LLDP)
        |-> (o_data.learn_event == EV_NONE))
        else $error("learn event on a frame that must not learn");

endmodule

bind mac_learning_forwarding_table mlft_assert u_mlft_assert (.*);

// ===== tb/mlft_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlft_checker
// watches both channels of the bridge table, keeps a shadow copy of the
// learning table, predicts the verdict word of every accepted frame and
// compares each returned word field by field, oldest first
// ----------------------------------------------------------------------------
module mlft_checker #(
    parameter int SETS = 256,
    parameter int WAYS = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  mlft_pkg::t_in  i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  mlft_pkg::t_out i_out_data,
    output int             o_errors,
    output int             o_pending
);
    import mlft_pkg::*;

    logic              shadow_valid [SETS*WAYS];
    logic [MAC_W-1:0]  shadow_mac   [SETS*WAYS];
    logic [PORT_W-1:0] shadow_port  [SETS*WAYS];

    t_out due_results [$];
    int   err_count = 0;

    function automatic int set_index(input logic [MAC_W-1:0] mac);
        logic [7:0] x;
        x = mac[47:40] ^ mac[39:32] ^ mac[31:24] ^ mac[23:16] ^ mac[15:8] ^ mac[7:0];
        return int'(x) % SETS;
    endfunction

    // first valid way holding the station, or -1
    function automatic int find_station(input logic [MAC_W-1:0] mac);
        int base;
        base = set_index(mac) * WAYS;
        for (int k = 0; k < WAYS; k++) begin
            if (shadow_valid[base+k] && shadow_mac[base+k] == mac) begin
                return base + k;
            end
        end
        return -1;
    endfunction

    task automatic learn_and_forward(input t_in frm, output t_out res);
        int slot;
        int base;
        res = '0;
        if (frm.src_mac == '0 || frm.dst_mac == '0 || frm.src_mac[GROUP_BIT]) begin
            res.verdict = V_DROP;
        end else if (frm.dst_mac[GROUP_BIT]) begin
            res.verdict = (frm.ether_type == LLDP_TYPE) ? V_LLDP : V_MCAST;
        end else begin
            slot = find_station(frm.src_mac);
            if (slot >= 0) begin
                if (shadow_port[slot] != frm.in_port) begin
                    res.old_port     = shadow_port[slot];
                    res.learn_event  = EV_MOVED;
                    shadow_port[slot] = frm.in_port;
                end
            end else begin
                res.learn_event = EV_FULL;
                base = set_index(frm.src_mac) * WAYS;
                for (int k = 0; k < WAYS; k++) begin
                    if (res.learn_event == EV_FULL && !shadow_valid[base+k]) begin
                        shadow_valid[base+k] = 1'b1;
                        shadow_mac[base+k]   = frm.src_mac;
                        shadow_port[base+k]  = frm.in_port;
                        res.learn_event      = EV_NEW;
                    end
                end
            end
            // destination lookup sees the entry just learned
            slot = find_station(frm.dst_mac);
            if (slot >= 0) begin
                res.verdict  = V_FWD;
                res.out_port = shadow_port[slot];
            end else begin
                res.verdict = V_FLOOD;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_out exp_word;
        t_out got_word;
        if (!i_rst_n) begin
            foreach (shadow_valid[k]) begin
                shadow_valid[k] = 1'b0;
            end
            due_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got_word = i_out_data;
                if (due_results.size() == 0) begin
                    $error("result word with nothing expected: %h", got_word);
                    err_count++;
                end else begin
                    exp_word = due_results.pop_front();
                    if (got_word.verdict !== exp_word.verdict) begin
                        $error("verdict: expected %0d, got %0d",
                               exp_word.verdict, got_word.verdict);
                        err_count++;
                    end
                    if (got_word.out_port !== exp_word.out_port) begin
                        $error("out_port: expected %0d, got %0d",
                               exp_word.out_port, got_word.out_port);
                        err_count++;
                    end
                    if (got_word.learn_event !== exp_word.learn_event) begin
                        $error("learn_event: expected %0d, got %0d",
                               exp_word.learn_event, got_word.learn_event);
                        err_count++;
                    end
                    if (got_word.old_port !== exp_word.old_port) begin
                        $error("old_port: expected %0d, got %0d",
                               exp_word.old_port, got_word.old_port);
                        err_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                learn_and_forward(i_in_data, exp_word);
                due_results.push_back(exp_word);
            end
        end
        o_pending <= due_results.size();
        o_errors  <= err_count;
    end

endmodule

// ===== tb/mac_learning_forwarding_table_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mac_learning_forwarding_table_test
// drives frames into the bridge table: a directed pass over drops, multicast,
// lldp, learning, station moves and full sets, then random traffic from a
// pool of stations, half of them crowded into four sets, with bursty input and a
// stalling receiver; the checker module predicts and compares
// ----------------------------------------------------------------------------
module mac_learning_forwarding_table_test;
    import mlft_pkg::*;

    localparam int SETS        = 256;
    localparam int WAYS        = 4;
    localparam int RAND_FRAMES = 900;
    localparam int POOL_SIZE   = 64;
    localparam int STALL_LIMIT = 5000;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_LONG} t_rx_mode;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     i_ready = 1'b0;
    t_in      i_data  = '0;
    logic     o_ready;
    logic     o_valid;
    t_out     o_data;

    int       chk_errors;
    int       chk_pending;
    int       idle_cycles = 0;
    int       burst_left  = 0;
    logic [7:0] rx_cyc    = '0;
    t_rx_mode rx_mode     = RX_OPEN;

    logic [MAC_W-1:0]  pool_mac  [POOL_SIZE];
    logic [PORT_W-1:0] pool_port [POOL_SIZE];

    mac_learning_forwarding_table #(.SETS(SETS), .WAYS(WAYS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    mlft_checker #(.SETS(SETS), .WAYS(WAYS)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_in_data   (i_data),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_out_data  (o_data),
        .o_errors    (chk_errors),
        .o_pending   (chk_pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // receiver picks a new stall pattern whenever the low six bits of its cycle count are zero
    always @(posedge i_clk) begin
        rx_cyc <= rx_cyc + 8'd1;
        if (rx_cyc[5:0] == '0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
        end
        case (rx_mode)
            RX_OPEN:     i_ready <= 1'b1;
            RX_RANDOM:   i_ready <= ($urandom_range(0, 9) < 6);
            RX_PERIODIC: i_ready <= (rx_cyc[2:0] < 3'd3);
            default:     i_ready <= (rx_cyc[4:0] >= 5'd12);
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("mac_learning_forwarding_table_test: errors");
            $finish;
        end
    end

    // random unicast mac whose octets xor to the given set
    function automatic logic [MAC_W-1:0] mac_in_set(input int set_no);
        logic [63:0]      r;
        logic [MAC_W-1:0] mac;
        r = {$urandom(), $urandom()};
        mac = r[MAC_W-1:0];
        mac[GROUP_BIT] = 1'b0;
        mac[7:0] = mac[47:40] ^ mac[39:32] ^ mac[31:24] ^ mac[23:16] ^ mac[15:8]
                   ^ set_no[7:0];
        return mac;
    endfunction

    function automatic int hot_set(input int slot);
        return (slot % 4) * 64 + 17;
    endfunction

    function automatic int pool_set(input int slot);
        return (slot < POOL_SIZE / 2) ? hot_set(slot) : $urandom_range(0, SETS - 1);
    endfunction

    function automatic logic [PORT_W-1:0] rand_port();
        return ($urandom_range(0, 3) != 0) ? PORT_W'($urandom_range(0, 7))
                                           : PORT_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [MAC_W-1:0] noise_mac();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            default: return r[MAC_W-1:0];
        endcase
    endfunction

    function automatic t_in frame_of(input logic [MAC_W-1:0] src, input logic [MAC_W-1:0] dst,
                                     input logic [ETYPE_W-1:0] etype,
                                     input logic [PORT_W-1:0] port);
        t_in f;
        f.src_mac    = src;
        f.dst_mac    = dst;
        f.ether_type = etype;
        f.in_port    = port;
        return f;
    endfunction

    // offers one word, holds it until taken, then maybe idles between bursts
    task automatic put_frame(input t_in f);
        int gap;
        i_valid <= 1'b1;
        i_data  <= f;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        t_in              f;
        int               pick;
        int               s;
        int               d;
        logic [MAC_W-1:0] sta;
        logic [MAC_W-1:0] stb;
        logic [MAC_W-1:0] stc;
        logic [MAC_W-1:0] mates [5];

        sta = 48'h02_11_22_33_44_55;
        stb = 48'h00_1b_21_0a_0b_0c;
        stc = mac_in_set(32'h3c);
        foreach (mates[k]) begin
            mates[k] = mac_in_set(32'ha5);
        end
        for (int k = 0; k < POOL_SIZE; k++) begin
            pool_mac[k]  = mac_in_set(pool_set(k));
            pool_port[k] = rand_port();
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drops, multicast and lldp classes
        put_frame(frame_of('0, stb, 16'h0800, 16'h0001));
        put_frame(frame_of(sta, '0, 16'h0800, 16'h0001));
        put_frame(frame_of(48'h01_00_5e_00_00_01, stb, 16'h0800, 16'h0001));
        put_frame(frame_of('1, stb, 16'h0800, 16'h0001));
        put_frame(frame_of(sta, 48'h01_00_5e_7f_00_01, 16'h0800, 16'h0001));
        put_frame(frame_of(sta, 48'h01_80_c2_00_00_0e, LLDP_TYPE, 16'h0001));
        put_frame(frame_of(sta, '1, 16'hffff, 16'h0001));
        // learning, unicast lldp, known station, move, source equal to destination
        put_frame(frame_of(sta, stb, 16'h0000, 16'h0000));
        put_frame(frame_of(stb, sta, LLDP_TYPE, 16'hffff));
        put_frame(frame_of(sta, stb, 16'h86dd, 16'h0000));
        put_frame(frame_of(sta, sta, 16'h0800, 16'h0005));
        put_frame(frame_of(stc, stc, 16'h0806, 16'h0007));
        // five stations in one set, the last finds it full
        foreach (mates[k]) begin
            put_frame(frame_of(mates[k], mates[0], 16'h0800, PORT_W'(16 + k)));
        end
        put_frame(frame_of(mates[4], mates[4], 16'h0800, 16'h0020));
        put_frame(frame_of(48'hfe_ff_ff_ff_ff_ff, sta, 16'hffff, 16'hffff));
        put_frame(frame_of(sta, 48'hfe_ff_ff_ff_ff_ff, 16'h0800, 16'h0005));

        for (int n = 0; n < RAND_FRAMES; n++) begin
            if (n == RAND_FRAMES / 2) begin
                drain_results();
            end
            pick = $urandom_range(0, 99);
            s = $urandom_range(0, POOL_SIZE - 1);
            d = $urandom_range(0, POOL_SIZE - 1);
            // fresh stations keep new entries and full sets coming
            if ($urandom_range(0, 19) == 0) begin
                pool_mac[s] = mac_in_set(pool_set(s));
            end
            if (pick < 80) begin
                if ($urandom_range(0, 6) == 0) begin
                    pool_port[s] = rand_port();
                end
                f.src_mac    = pool_mac[s];
                f.dst_mac    = ($urandom_range(0, 6) == 0) ? mac_in_set($urandom_range(0, 255))
                                                           : pool_mac[d];
                f.ether_type = ($urandom_range(0, 9) == 0) ? LLDP_TYPE
                                                           : ETYPE_W'($urandom_range(0, 65535));
                f.in_port    = pool_port[s];
            end else if (pick < 90) begin
                f.src_mac    = pool_mac[s];
                f.dst_mac    = pool_mac[d];
                f.dst_mac[GROUP_BIT] = 1'b1;
                f.ether_type = ($urandom_range(0, 1) == 0) ? LLDP_TYPE
                                                           : ETYPE_W'($urandom_range(0, 65535));
                f.in_port    = rand_port();
            end else begin
                f.src_mac    = noise_mac();
                f.dst_mac    = noise_mac();
                f.ether_type = ($urandom_range(0, 3) == 0) ? LLDP_TYPE
                                                           : ETYPE_W'($urandom_range(0, 65535));
                f.in_port    = PORT_W'($urandom_range(0, 65535));
            end
            put_frame(f);
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (chk_errors == 0) begin
            $display("mac_learning_forwarding_table_test: clean");
        end else begin
            $display("mac_learning_forwarding_table_test: errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/mlft_pkg.sv
src/mlft_front.sv
src/mlft_queue.sv
src/mlft_back.sv
src/mac_learning_forwarding_table.sv
src/mlft_checker.sv
tb/mlft_checker.sv
tb/mac_learning_forwarding_table_test.sv
